/* rtl/tef_pkg.sv */
`default_nettype none

package tef_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int ACT_W   = 2;
    localparam int TYPE_W  = 8;
    localparam int TAG_W   = 32;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 5;

    localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_GET  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0] ev_type;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] stamp;
    } tef_entry_t;

    typedef struct packed {
        logic load_in;
        logic exec;
    } tef_cmd_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/timestamped_event_fifo.sv */
// an accepted item goes to the input registers, then executes once the output is free
// execute loads the result registers; no new item is taken before the last has executed
// in_stall rises for the execute cycle and holds while a finished result is not taken
// reset: asynchronous active-low, empties the queue and clears pointers and seconds counter
// event memory contents are not cleared by reset
`default_nettype none

module timestamped_event_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [tef_pkg::ACT_W-1:0]      action,
    input  wire logic [tef_pkg::TYPE_W-1:0]     event_type,
    input  wire logic [tef_pkg::TAG_W-1:0]      tag_id,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [tef_pkg::STAT_W-1:0]     status,
    output logic                                event_valid,
    output logic      [tef_pkg::TYPE_W-1:0]     out_type,
    output logic      [tef_pkg::TAG_W-1:0]      out_tag,
    output logic      [tef_pkg::TIME_W-1:0]     age_seconds,
    output logic      [tef_pkg::FILL_W-1:0]     fill_count
);

    tef_pkg::tef_cmd_t cmd;

    tef_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tef_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .event_type  (event_type),
        .tag_id      (tag_id),
        .status      (status),
        .event_valid (event_valid),
        .out_type    (out_type),
        .out_tag     (out_tag),
        .age_seconds (age_seconds),
        .fill_count  (fill_count)
    );

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && cmd.exec == 1'b0 || in_stall))
        else $error("input accepted without entering execute");

    a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> out_valid)
        else $error("executed item did not produce a result");

    a_event_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_valid) |-> (status == tef_pkg::ST_OK))
        else $error("returned event with non-ok status");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == tef_pkg::ST_FULL)
            |-> (fill_count == tef_pkg::FILL_W'(tef_pkg::QUEUE_DEPTH)))
        else $error("full status with queue not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == tef_pkg::ST_EMPTY) |-> (fill_count == '0 && !event_valid))
        else $error("empty status with events held");

endmodule

`default_nettype wire

/* rtl/tef_ctrl.sv */
`default_nettype none

module tef_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output tef_pkg::tef_cmd_t      cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load_in    = 1'b0;
        cmd.exec       = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/tef_dp.sv */
`default_nettype none

module tef_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tef_pkg::tef_cmd_t              cmd,
    input  wire logic [tef_pkg::ACT_W-1:0]      action,
    input  wire logic [tef_pkg::TYPE_W-1:0]     event_type,
    input  wire logic [tef_pkg::TAG_W-1:0]      tag_id,
    output logic      [tef_pkg::STAT_W-1:0]     status,
    output logic                                event_valid,
    output logic      [tef_pkg::TYPE_W-1:0]     out_type,
    output logic      [tef_pkg::TAG_W-1:0]      out_tag,
    output logic      [tef_pkg::TIME_W-1:0]     age_seconds,
    output logic      [tef_pkg::FILL_W-1:0]     fill_count
);

    tef_pkg::tef_entry_t mem [tef_pkg::QUEUE_DEPTH];
    tef_pkg::tef_entry_t rd_data_reg;
    tef_pkg::tef_entry_t wr_entry;
    logic                mem_we;

    logic [tef_pkg::ACT_W-1:0]  act_reg;
    logic [tef_pkg::TYPE_W-1:0] type_in_reg;
    logic [tef_pkg::TAG_W-1:0]  tag_in_reg;

    logic [tef_pkg::PTR_W-1:0]  rd_ptr_reg;
    logic [tef_pkg::PTR_W-1:0]  rd_ptr_next;
    logic [tef_pkg::PTR_W-1:0]  wr_ptr_reg;
    logic [tef_pkg::PTR_W-1:0]  wr_ptr_next;
    logic [tef_pkg::CNT_W-1:0]  count_reg;
    logic [tef_pkg::CNT_W-1:0]  count_next;
    logic [tef_pkg::TIME_W-1:0] secs_reg;
    logic [tef_pkg::TIME_W-1:0] secs_next;

    logic [tef_pkg::STAT_W-1:0] res_status;
    logic                       res_valid;
    logic [tef_pkg::TYPE_W-1:0] res_type;
    logic [tef_pkg::TAG_W-1:0]  res_tag;
    logic [tef_pkg::TIME_W-1:0] res_age;

    logic [tef_pkg::STAT_W-1:0] status_reg;
    logic                       event_valid_reg;
    logic [tef_pkg::TYPE_W-1:0] out_type_reg;
    logic [tef_pkg::TAG_W-1:0]  out_tag_reg;
    logic [tef_pkg::TIME_W-1:0] age_reg;
    logic [tef_pkg::FILL_W-1:0] fill_reg;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        secs_next   = secs_reg;
        mem_we      = 1'b0;
        wr_entry    = '{ev_type: type_in_reg, tag: tag_in_reg, stamp: secs_reg};
        res_status  = tef_pkg::ST_OK;
        res_valid   = 1'b0;
        res_type    = '0;
        res_tag     = '0;
        res_age     = '0;
        if (cmd.exec)
        begin
            case (act_reg)
                tef_pkg::ACT_TICK:
                begin
                    secs_next = secs_reg + tef_pkg::TIME_W'(1);
                end
                tef_pkg::ACT_ADD:
                begin
                    if (count_reg == tef_pkg::CNT_W'(tef_pkg::QUEUE_DEPTH))
                    begin
                        res_status = tef_pkg::ST_FULL;
                    end
                    else
                    begin
                        // an add to an empty queue restarts the clock
                        if (count_reg == '0)
                        begin
                            secs_next      = '0;
                            wr_entry.stamp = '0;
                        end
                        mem_we      = 1'b1;
                        wr_ptr_next = tef_pkg::ptr_inc(wr_ptr_reg);
                        count_next  = count_reg + tef_pkg::CNT_W'(1);
                    end
                end
                tef_pkg::ACT_GET:
                begin
                    if (count_reg == '0)
                    begin
                        res_status = tef_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        res_valid   = 1'b1;
                        res_type    = rd_data_reg.ev_type;
                        res_tag     = rd_data_reg.tag;
                        res_age     = secs_reg - rd_data_reg.stamp;
                        rd_ptr_next = tef_pkg::ptr_inc(rd_ptr_reg);
                        count_next  = count_reg - tef_pkg::CNT_W'(1);
                        if (count_reg == tef_pkg::CNT_W'(1))
                        begin
                            secs_next = '0;
                        end
                    end
                end
                default:
                begin
                    res_status = tef_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg     <= action;
            type_in_reg <= event_type;
            tag_in_reg  <= tag_id;
        end
        if (cmd.exec)
        begin
            status_reg      <= res_status;
            event_valid_reg <= res_valid;
            out_type_reg    <= res_type;
            out_tag_reg     <= res_tag;
            age_reg         <= res_age;
            fill_reg        <= tef_pkg::FILL_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
            secs_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            secs_reg   <= secs_next;
        end
    end

    assign status      = status_reg;
    assign event_valid = event_valid_reg;
    assign out_type    = out_type_reg;
    assign out_tag     = out_tag_reg;
    assign age_seconds = age_reg;
    assign fill_count  = fill_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_timestamped_event_fifo.sv */
`default_nettype none

module tb_timestamped_event_fifo;

    import tef_pkg::*;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
    localparam int RAND_ITEMS  = 1420;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              ev_valid;
        logic [TYPE_W-1:0] ev_type;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] age;
        logic [FILL_W-1:0] fill;
    } evt_result_t;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [TYPE_W-1:0] ev_type;
        logic [TAG_W-1:0]  tag;
        int                reps;
        bit                typed;
        evt_result_t       want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ACT_W-1:0] action = '0;
    logic [TYPE_W-1:0] event_type = '0;
    logic [TAG_W-1:0] tag_id = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic event_valid;
    logic [TYPE_W-1:0] out_type;
    logic [TAG_W-1:0] out_tag;
    logic [TIME_W-1:0] age_seconds;
    logic [FILL_W-1:0] fill_count;

    // typed-in expectation travels with the item
    bit          item_typed = 1'b0;
    evt_result_t item_want = '0;

    // queue model state
    logic [TYPE_W-1:0] mdl_type [QUEUE_DEPTH];
    logic [TAG_W-1:0]  mdl_tag [QUEUE_DEPTH];
    logic [TIME_W-1:0] mdl_stamp [QUEUE_DEPTH];
    logic [PTR_W-1:0]  mdl_rd = '0;
    logic [PTR_W-1:0]  mdl_wr = '0;
    logic              mdl_empty = 1'b1;
    logic [TIME_W-1:0] mdl_secs = '0;

    evt_result_t pending_q [$];
    evt_result_t mdl_res;
    evt_result_t want_res;
    dir_row_t    dir_rows [$];
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    int          stall_tick = 0;
    int          stall_mode = 0;

    timestamped_event_fifo i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .event_type  (event_type),
        .tag_id      (tag_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .event_valid (event_valid),
        .out_type    (out_type),
        .out_tag     (out_tag),
        .age_seconds (age_seconds),
        .fill_count  (fill_count)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic int held_events();
        int n;
        if (mdl_empty)
        begin
            n = 0;
        end
        else if (mdl_wr > mdl_rd)
        begin
            n = int'(mdl_wr) - int'(mdl_rd);
        end
        else
        begin
            n = int'(mdl_wr) + QUEUE_DEPTH - int'(mdl_rd);
        end
        return n;
    endfunction

    function automatic evt_result_t queue_step(input logic [ACT_W-1:0] act,
                                               input logic [TYPE_W-1:0] typ,
                                               input logic [TAG_W-1:0] tag);
        evt_result_t r;
        r = '0;
        r.status = ST_OK;
        if (act == ACT_TICK)
        begin
            mdl_secs = mdl_secs + 1'b1;
        end
        else if (act == ACT_ADD)
        begin
            if (held_events() == QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                if (mdl_empty)
                begin
                    mdl_secs = '0;
                    mdl_empty = 1'b0;
                end
                mdl_type[mdl_wr] = typ;
                mdl_tag[mdl_wr] = tag;
                mdl_stamp[mdl_wr] = mdl_secs;
                mdl_wr = mdl_wr + 1'b1;
            end
        end
        else if (act == ACT_GET)
        begin
            if (mdl_empty)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.ev_valid = 1'b1;
                r.ev_type = mdl_type[mdl_rd];
                r.tag = mdl_tag[mdl_rd];
                r.age = mdl_secs - mdl_stamp[mdl_rd];
                mdl_rd = mdl_rd + 1'b1;
                if (mdl_rd == mdl_wr)
                begin
                    mdl_secs = '0;
                    mdl_empty = 1'b1;
                end
            end
        end
        r.fill = FILL_W'(held_events());
        return r;
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            fail_cnt++;
        end
    endtask

    // input acceptance first, then result checking, in one process
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                mdl_res = queue_step(action, event_type, tag_id);
                if (item_typed)
                begin
                    pending_q.push_back(item_want);
                end
                else
                begin
                    pending_q.push_back(mdl_res);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result with no item pending");
                    fail_cnt++;
                end
                else
                begin
                    want_res = pending_q.pop_front();
                    cmp_field("status", 32'(want_res.status), 32'(status));
                    cmp_field("event_valid", 32'(want_res.ev_valid), 32'(event_valid));
                    cmp_field("out_type", 32'(want_res.ev_type), 32'(out_type));
                    cmp_field("out_tag", want_res.tag, out_tag);
                    cmp_field("age_seconds", want_res.age, age_seconds);
                    cmp_field("fill_count", 32'(want_res.fill), 32'(fill_count));
                end
            end
        end
    end

    // receiver stall pattern, with the mode redrawn at random among four patterns
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            2: out_stall <= ($urandom_range(0, 7) != 0);
            default: out_stall <= ((stall_tick / 4) % 2 == 1);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_timestamped_event_fifo NOT OK");
            $finish;
        end
    end

    task automatic add_row(input logic [ACT_W-1:0] act, input logic [TYPE_W-1:0] typ,
                           input logic [TAG_W-1:0] tag, input int reps, input bit typed,
                           input logic [STAT_W-1:0] st, input int fill);
        dir_row_t r;
        r.act = act;
        r.ev_type = typ;
        r.tag = tag;
        r.reps = reps;
        r.typed = typed;
        r.want = '0;
        r.want.status = st;
        r.want.fill = FILL_W'(fill);
        dir_rows.push_back(r);
    endtask

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [TYPE_W-1:0] typ,
                             input logic [TAG_W-1:0] tag, input bit typed,
                             input evt_result_t want);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(50, 200);
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
            end
        end
        in_valid <= 1'b1;
        action <= act;
        event_type <= typ;
        tag_id <= tag;
        item_typed <= typed;
        item_want <= want;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        burst_left--;
    endtask

    // hold the sender until every pending result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_q.size() != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        burst_left = 0;
    endtask

    initial
    begin
        int                roll;
        bit                add_heavy;
        logic [ACT_W-1:0]  act;
        logic [TYPE_W-1:0] typ;
        logic [TAG_W-1:0]  tag;

        add_heavy = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(ACT_GET, 8'h00, 32'h0, 1, 1'b1, ST_EMPTY, 0);
        add_row(ACT_NONE, 8'hff, 32'hffff_ffff, 1, 1'b1, ST_OK, 0);
        add_row(ACT_TICK, 8'h00, 32'h0, 1, 1'b1, ST_OK, 0);
        add_row(ACT_ADD, 8'h00, 32'h0, 1, 1'b1, ST_OK, 1);
        add_row(ACT_ADD, 8'hff, 32'hffff_ffff, 1, 1'b1, ST_OK, 2);
        add_row(ACT_TICK, 8'h00, 32'h0, 2, 1'b0, ST_OK, 0);
        add_row(ACT_GET, 8'h00, 32'h0, 2, 1'b0, ST_OK, 0);
        add_row(ACT_GET, 8'h00, 32'h0, 1, 1'b1, ST_EMPTY, 0);
        add_row(ACT_ADD, 8'h5a, 32'ha5a5_a5a5, 16, 1'b0, ST_OK, 0);
        add_row(ACT_ADD, 8'h3c, 32'h1234_5678, 1, 1'b1, ST_FULL, 16);
        add_row(ACT_TICK, 8'h00, 32'h0, 1, 1'b0, ST_OK, 0);
        add_row(ACT_GET, 8'h00, 32'h0, 1, 1'b0, ST_OK, 0);

        foreach (dir_rows[i])
        begin
            for (int k = 0; k < dir_rows[i].reps; k++)
            begin
                send_item(dir_rows[i].act, dir_rows[i].ev_type + TYPE_W'(k),
                          dir_rows[i].tag + TAG_W'(k), dir_rows[i].typed,
                          dir_rows[i].want);
            end
        end
        drain_results();

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                add_heavy = ~add_heavy;
            end
            roll = $urandom_range(0, 99);
            if (add_heavy)
            begin
                act = (roll < 55) ? ACT_ADD : (roll < 75) ? ACT_GET :
                      (roll < 97) ? ACT_TICK : ACT_NONE;
            end
            else
            begin
                act = (roll < 20) ? ACT_ADD : (roll < 70) ? ACT_GET :
                      (roll < 97) ? ACT_TICK : ACT_NONE;
            end
            roll = $urandom_range(0, 9);
            typ = (roll == 0) ? '0 : (roll == 1) ? '1 : TYPE_W'($urandom_range(0, 255));
            tag = (roll == 0) ? '0 : (roll == 1) ? '1 : TAG_W'($urandom);
            send_item(act, typ, tag, 1'b0, '0);
            if (n % 300 == 150)
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_cnt == 0 && pending_q.size() == 0)
        begin
            $display("tb_timestamped_event_fifo OK");
        end
        else
        begin
            $display("tb_timestamped_event_fifo NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
